@@ rtl/core/ptc_pkg.sv @@
package ptc_pkg;

   // saturation bound used by most rounding steps
   localparam logic [63:0] CAP61 = 64'h2000_0000_0000_0000;

   // reading kinds
   localparam logic CMD_TEMP = 1'b0;
   localparam logic CMD_PRES = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
      logic [6:0]  k;      // rounding shift, at least 1
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] prod;   // low half of the full product
      logic [63:0] res;    // round(a*b / 2^k), saturated at CAP61
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] cap;
      logic [6:0]  s;      // result is round(n * 2^s / d)
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] q;
   } div_rsp_type;

   function automatic logic [63:0] mag(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] to_signed(input logic [63:0] m, input logic neg);
      return neg ? -signed'(m) : signed'(m);
   endfunction

   // round(v / 2^k), ties away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned k);
      logic [63:0] m;
      logic [63:0] r;
      m = mag(v);
      r = (m + (64'd1 << (k - 1))) >> k;
      return to_signed(r, v[63]);
   endfunction

endpackage

@@ rtl/core/ptc_mul.sv @@
module ptc_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  ptc_pkg::mul_req_type  req,
   output ptc_pkg::mul_rsp_type  rsp
);
   import ptc_pkg::*;

   logic         busy_ff;
   logic         done_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  a_ff;
   logic [63:0]  b_ff;
   logic [6:0]   k_ff;
   logic [127:0] acc_ff;
   logic [63:0]  res_ff;

   logic [15:0]  chunk;
   logic [79:0]  part;
   logic [127:0] rnd;
   logic [127:0] shd;

   // one 64x16 partial product per cycle, then a rounding step
   always_comb begin
      chunk = b_ff[{cnt_ff[1:0], 4'b0} +: 16];
      part  = a_ff * chunk;
      rnd   = acc_ff + (128'd1 << (k_ff - 7'd1));
      shd   = rnd >> k_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            a_ff    <= req.a;
            b_ff    <= req.b;
            k_ff    <= req.k;
            acc_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff[2]) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               res_ff  <= (shd[127:64] != 64'd0 || shd[63:0] > CAP61) ? CAP61 : shd[63:0];
            end else begin
               acc_ff <= acc_ff + (128'(part) << {cnt_ff[1:0], 4'b0});
               cnt_ff <= cnt_ff + 3'd1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff[63:0];
   assign rsp.res  = res_ff;

endmodule

@@ rtl/core/ptc_div.sv @@
module ptc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ptc_pkg::div_req_type  req,
   output ptc_pkg::div_rsp_type  rsp
);
   import ptc_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   logic        sat_ff;
   logic [6:0]  cnt_ff;
   logic [63:0] dvd_ff;
   logic [63:0] r_ff;
   logic [63:0] d_ff;
   logic [63:0] q_ff;
   logic [63:0] cap_ff;
   logic [63:0] lim_ff;
   logic [63:0] res_ff;

   logic [63:0] r2;
   logic        ge;
   logic [63:0] rn;
   logic [63:0] qn;

   // restoring step: one quotient bit per cycle
   always_comb begin
      r2 = {r_ff[62:0], dvd_ff[63]};
      ge = (r2 >= d_ff);
      rn = ge ? r2 - d_ff : r2;
      qn = {q_ff[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         sat_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            dvd_ff  <= req.n;
            d_ff    <= req.d;
            cap_ff  <= req.cap;
            lim_ff  <= req.cap << 1;
            cnt_ff  <= 7'd65 + req.s;
            r_ff    <= '0;
            q_ff    <= '0;
            sat_ff  <= 1'b0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff == 7'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               res_ff  <= sat_ff ? cap_ff : (q_ff + 64'd1) >> 1;
            end else begin
               dvd_ff <= dvd_ff << 1;
               r_ff   <= rn;
               cnt_ff <= cnt_ff - 7'd1;
               // quotient only grows, so an overrun is final
               if (!sat_ff) begin
                  if (qn > lim_ff) begin
                     sat_ff <= 1'b1;
                  end else begin
                     q_ff <= qn;
                  end
               end
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.q    = res_ff;

endmodule

@@ rtl/core/pressure_temperature_compensation.sv @@
// Barometric sensor compensation.
// req channel: one raw reading per beat. tuser is the reading kind (0 temperature,
// 1 pressure); tdata carries the raw word and the extra fraction byte of a pressure
// reading. rsp channel: one result beat per reading with the kind echoed on tuser,
// temperature and pressure in 1/256 units and a status (ok, zero divisor, saturated).
// csr port: calibration words are written by index. They must be written only while the
// block is idle; the block itself does not enforce this. A temperature reading updates
// the kept temperature that later pressure readings use. A temperature reading takes
// one multiplier pass and two passes through the bit-serial divider, a pressure reading
// ten passes through the multiplier and one divider pass. One reading is in work at a
// time; req_tready is high only while the sequencer is idle.
// A finished result sits in the output register; the next reading is accepted while it
// waits. If the receiver stalls, the following result holds in the sequencer until the
// output register frees up.
// Reset clears the calibration words, the kept temperature (zero degrees) and the
// output valid.
module pressure_temperature_compensation #(
   parameter int INTERNAL_FRACTION_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // raw_word[15:0], raw_fraction[23:16]
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // temperature[15:0], pressure[34:16], status[36:35]
   output logic        rsp_tuser,   // kind
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import ptc_pkg::*;

   localparam int F = INTERNAL_FRACTION_BITS;
   localparam logic [63:0] P0   = (((64'd3783 << (F + 1)) / 64'd1600) + 64'd1) >> 1;
   localparam logic [63:0] ZCAP = 64'd1 << (20 + F);

   localparam logic [1:0] REG_CAL_A = 2'd0;
   localparam logic [1:0] REG_CAL_B = 2'd1;
   localparam logic [1:0] REG_CAL_C = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE, S_T_PROD, S_T_DIVA, S_T_DIVQ, S_T_FIN,
      S_P_SQ, S_P_X2, S_P_XV, S_P_Y3, S_P_YV, S_P_CHK,
      S_P_DD, S_P_NM, S_P_Z, S_P_G, S_P_P2, S_P_P1, S_P_FIN, S_OUT
   } state_type;

   state_type state_ff;

   logic [63:0] cal_a_ff;
   logic [63:0] cal_b_ff;
   logic [31:0] cal_c_ff;
   logic signed [15:0] last_t_ff;

   logic        cmd_ff;
   logic [15:0] raw_ff;
   logic [7:0]  frac_ff;
   logic        neg_ff;
   logic        zneg_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] d_ff;
   logic signed [63:0] a_ff;
   logic signed [63:0] sum_ff;
   logic signed [63:0] x_ff;
   logic signed [63:0] y_ff;
   logic signed [63:0] y35_ff;
   logic signed [63:0] n_ff;
   logic [63:0] sq_ff;
   logic [63:0] dd_ff;
   logic [63:0] zm_ff;
   logic [63:0] p2_ff;

   logic signed [15:0] res_temp_ff;
   logic [18:0]        res_pres_ff;
   logic [1:0]         res_stat_ff;

   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic signed [15:0] rsp_temp_ff;
   logic [18:0]        rsp_pres_ff;
   logic [1:0]         rsp_stat_ff;

   mul_req_type mul_req_ff;
   mul_rsp_type mul_rsp;
   div_req_type div_req_ff;
   div_rsp_type div_rsp;

   logic signed [63:0] ac1, ac2, ac3, ac4, ac5, ac6, vb1, vb2, mc, md;
   logic signed [63:0] s8, prod_sg, d_sum, t8, p8, y35, n_val;

   ptc_mul u_mul (.clock(clock), .reset(reset), .req(mul_req_ff), .rsp(mul_rsp));
   ptc_div u_div (.clock(clock), .reset(reset), .req(div_req_ff), .rsp(div_rsp));

   // calibration fields and per-step arithmetic
   always_comb begin
      ac1 = 64'(signed'(cal_a_ff[63:48]));
      ac2 = 64'(signed'(cal_a_ff[47:32]));
      ac3 = 64'(signed'(cal_a_ff[31:16]));
      ac4 = signed'({48'd0, cal_a_ff[15:0]});
      ac5 = signed'({48'd0, cal_b_ff[63:48]});
      ac6 = signed'({48'd0, cal_b_ff[47:32]});
      vb1 = 64'(signed'(cal_b_ff[31:16]));
      vb2 = 64'(signed'(cal_b_ff[15:0]));
      mc  = 64'(signed'(cal_c_ff[31:16]));
      md  = 64'(signed'(cal_c_ff[15:0]));
      s8       = 64'(last_t_ff) - 64'sd6400;
      prod_sg  = to_signed(mul_rsp.prod, neg_ff);
      d_sum    = prod_sg + (md <<< 15);
      t8       = round_shift(sum_ff, F - 8);
      p8       = round_shift(sum_ff, F - 8);
      y35      = round_shift(y_ff, 16);
      n_val    = (signed'({40'd0, raw_ff, frac_ff}) <<< 23) - x_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cal_a_ff     <= '0;
         cal_b_ff     <= '0;
         cal_c_ff     <= '0;
         last_t_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         mul_req_ff.start <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         mul_req_ff.start <= 1'b0;
         div_req_ff.start <= 1'b0;

         // configuration writes
         if (csr_wen) begin
            unique case (csr_index)
               REG_CAL_A: cal_a_ff <= csr_wdata;
               REG_CAL_B: cal_b_ff <= csr_wdata;
               REG_CAL_C: cal_c_ff <= csr_wdata[31:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff      <= req_tuser;
                  raw_ff      <= req_tdata[15:0];
                  frac_ff     <= req_tdata[23:16];
                  res_temp_ff <= last_t_ff;
                  res_pres_ff <= '0;
                  res_stat_ff <= ST_OK;
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.k     <= 7'd1;
                  if (req_tuser == CMD_TEMP) begin
                     mul_req_ff.a <= mag(signed'({48'd0, req_tdata[15:0]}) - ac6);
                     mul_req_ff.b <= 64'(ac5);
                     neg_ff       <= (signed'({48'd0, req_tdata[15:0]}) - ac6) < 0;
                     state_ff     <= S_T_PROD;
                  end else begin
                     mul_req_ff.a <= mag(s8);
                     mul_req_ff.b <= mag(s8);
                     neg_ff       <= 1'b0;
                     state_ff     <= S_P_SQ;
                  end
               end
            end

            // temperature: a = c5*(tu-c6) scaled, q = mc/(a+md) scaled
            S_T_PROD: begin
               if (mul_rsp.done) begin
                  prod_ff <= prod_sg;
                  d_ff    <= d_sum;
                  if (d_sum == 64'sd0) begin
                     res_stat_ff <= ST_DIV0;
                     state_ff    <= S_OUT;
                  end else begin
                     div_req_ff.start <= 1'b1;
                     div_req_ff.n     <= mul_rsp.prod;
                     div_req_ff.d     <= 64'd160;
                     div_req_ff.cap   <= CAP61;
                     div_req_ff.s     <= 7'(F - 15);
                     state_ff         <= S_T_DIVA;
                  end
               end
            end

            S_T_DIVA: begin
               if (div_rsp.done) begin
                  a_ff <= to_signed(div_rsp.q, prod_ff < 0);
                  div_req_ff.start <= 1'b1;
                  div_req_ff.n     <= mag(mc);
                  div_req_ff.d     <= (mag(d_ff) << 2) + mag(d_ff);
                  div_req_ff.cap   <= CAP61;
                  div_req_ff.s     <= 7'(F + 21);
                  state_ff         <= S_T_DIVQ;
               end
            end

            S_T_DIVQ: begin
               if (div_rsp.done) begin
                  sum_ff   <= a_ff + to_signed(div_rsp.q, (mc < 0) != (d_ff < 0));
                  state_ff <= S_T_FIN;
               end
            end

            S_T_FIN: begin
               if (t8 > 64'sd32767) begin
                  res_temp_ff <= 16'sh7FFF;
                  last_t_ff   <= 16'sh7FFF;
                  res_stat_ff <= ST_SAT;
               end else if (t8 < -64'sd32768) begin
                  res_temp_ff <= 16'sh8000;
                  last_t_ff   <= 16'sh8000;
                  res_stat_ff <= ST_SAT;
               end else begin
                  res_temp_ff <= t8[15:0];
                  last_t_ff   <= t8[15:0];
               end
               state_ff <= S_OUT;
            end

            // pressure: x and y polynomials in s8
            S_P_SQ: begin
               if (mul_rsp.done) begin
                  sq_ff <= mul_rsp.prod;
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= (mag(ac2) << 2) + mag(ac2);
                  mul_req_ff.b     <= mag(s8);
                  neg_ff           <= (ac2 < 0) != (s8 < 0);
                  state_ff         <= S_P_X2;
               end
            end

            S_P_X2: begin
               if (mul_rsp.done) begin
                  x_ff <= (ac1 <<< 31) + (prod_sg <<< 15);
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= (mag(vb2) << 4) + (mag(vb2) << 3) + mag(vb2);
                  mul_req_ff.b     <= sq_ff;
                  neg_ff           <= vb2 < 0;
                  state_ff         <= S_P_XV;
               end
            end

            S_P_XV: begin
               if (mul_rsp.done) begin
                  x_ff <= x_ff + prod_sg;
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= (mag(ac3) << 2) + mag(ac3);
                  mul_req_ff.b     <= mag(s8);
                  neg_ff           <= (ac3 < 0) != (s8 < 0);
                  state_ff         <= S_P_Y3;
               end
            end

            S_P_Y3: begin
               if (mul_rsp.done) begin
                  y_ff <= (64'sd1 <<< 51) + (prod_sg <<< 18);
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= (mag(vb1) << 4) + (mag(vb1) << 3) + mag(vb1);
                  mul_req_ff.b     <= sq_ff;
                  neg_ff           <= vb1 < 0;
                  state_ff         <= S_P_YV;
               end
            end

            S_P_YV: begin
               if (mul_rsp.done) begin
                  y_ff     <= y_ff + prod_sg;
                  state_ff <= S_P_CHK;
               end
            end

            S_P_CHK: begin
               if (ac4 == 64'sd0 || y35 == 64'sd0) begin
                  res_stat_ff <= ST_DIV0;
                  state_ff    <= S_OUT;
               end else begin
                  y35_ff <= y35;
                  n_ff   <= n_val;
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= 64'(ac4);
                  mul_req_ff.b     <= mag(y35);
                  state_ff         <= S_P_DD;
               end
            end

            S_P_DD: begin
               if (mul_rsp.done) begin
                  dd_ff <= mul_rsp.prod;
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= mag(n_ff);
                  mul_req_ff.b     <= 64'd1000;
                  state_ff         <= S_P_NM;
               end
            end

            // z = (pu - x) / y, numerator kept modulo 2^64
            S_P_NM: begin
               if (mul_rsp.done) begin
                  zneg_ff <= (n_ff < 0) != (y35_ff < 0);
                  div_req_ff.start <= 1'b1;
                  div_req_ff.n     <= mul_rsp.prod;
                  div_req_ff.d     <= dd_ff;
                  div_req_ff.cap   <= ZCAP;
                  div_req_ff.s     <= 7'(F + 4);
                  state_ff         <= S_P_Z;
               end
            end

            S_P_Z: begin
               if (div_rsp.done) begin
                  zm_ff <= div_rsp.q;
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= div_rsp.q;
                  mul_req_ff.b     <= 64'd303800;
                  mul_req_ff.k     <= 7'd36;
                  state_ff         <= S_P_G;
               end
            end

            S_P_G: begin
               if (mul_rsp.done) begin
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= mul_rsp.res;
                  mul_req_ff.b     <= zm_ff;
                  mul_req_ff.k     <= 7'(F);
                  state_ff         <= S_P_P2;
               end
            end

            S_P_P2: begin
               if (mul_rsp.done) begin
                  p2_ff <= mul_rsp.res;
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= zm_ff;
                  mul_req_ff.b     <= 64'd7357;
                  mul_req_ff.k     <= 7'd20;
                  state_ff         <= S_P_P1;
               end
            end

            S_P_P1: begin
               if (mul_rsp.done) begin
                  sum_ff <= signed'(p2_ff) + to_signed(zm_ff, zneg_ff)
                            - to_signed(mul_rsp.res, zneg_ff) + signed'(P0);
                  state_ff <= S_P_FIN;
               end
            end

            S_P_FIN: begin
               if (p8 > 64'sd524287) begin
                  res_pres_ff <= 19'h7FFFF;
                  res_stat_ff <= ST_SAT;
               end else if (p8 < 0) begin
                  res_pres_ff <= '0;
                  res_stat_ff <= ST_SAT;
               end else begin
                  res_pres_ff <= p8[18:0];
               end
               state_ff <= S_OUT;
            end

            // hand the result to the output register once it is free
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= cmd_ff;
                  rsp_temp_ff  <= res_temp_ff;
                  rsp_pres_ff  <= res_pres_ff;
                  rsp_stat_ff  <= res_stat_ff;
                  state_ff     <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {3'b000, rsp_stat_ff, rsp_pres_ff, rsp_temp_ff};

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import ptc_pkg::*;

   localparam int FRAC_BITS = 24;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;

   // calibration register indexes
   localparam logic [1:0] CAL_A = 2'd0;
   localparam logic [1:0] CAL_B = 2'd1;
   localparam logic [1:0] CAL_C = 2'd2;

   localparam longint unsigned SAT61 = 64'h2000_0000_0000_0000;

   typedef struct packed {
      logic        kind;
      logic [15:0] temperature;
      logic [18:0] pressure;
      logic [1:0]  status;
   } reading_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // raw_word[15:0], raw_fraction[23:16]
   logic        req_tuser = 1'b0; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // temperature[15:0], pressure[34:16], status[36:35]
   logic        rsp_tuser;        // kind
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // predictor copy of calibration and kept temperature
   logic [63:0] pred_cal_a, pred_cal_b, pred_cal_c;
   logic signed [15:0] pred_kept_temp;

   reading_result_type pending_results[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int idle_cycles = 0;

   pressure_temperature_compensation dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic longint signed sx16(input logic [15:0] v);
      return longint'(shortint'(v));
   endfunction

   function automatic longint unsigned magnitude(input longint signed v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint signed apply_sign(input longint unsigned m, input bit neg);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   // round(v / 2^k), ties away from zero
   function automatic longint signed shift_round(input longint signed v, input int k);
      longint unsigned m;
      m = (magnitude(v) + (64'd1 << (k - 1))) >> k;
      return apply_sign(m, v < 0);
   endfunction

   // round(n * 2^s / d), saturated at cap
   function automatic longint unsigned scaled_quotient(input longint unsigned n, input int s,
                                                      input longint unsigned d,
                                                      input longint unsigned cap);
      longint unsigned q, r, lim;
      q = n / d;
      r = n % d;
      lim = 2 * cap;
      if (q > cap) return cap;
      for (int i = 0; i <= s; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= d) begin
            r = r - d;
            q = q + 1;
         end
         if (q > lim) return cap;
      end
      return (q + 1) >> 1;
   endfunction

   // round(a * b / 2^k) on the full product, saturated at cap
   function automatic longint unsigned scaled_product(input longint unsigned a,
                                                     input longint unsigned b, input int k,
                                                     input longint unsigned cap);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      p = (p + (128'd1 << (k - 1))) >> k;
      if (p[127:64] != 0 || p[63:0] > cap) return cap;
      return p[63:0];
   endfunction

   function automatic reading_result_type compensate(input logic cmd, input logic [15:0] raw,
                                                     input logic [7:0] frac);
      reading_result_type res;
      longint signed ac1, ac2, ac3, ac4, ac5, ac6, vb1, vb2, mc, md;
      longint signed prod, dsum, a, q, t8, s8, x31, y51, y35, n, z, p2z2, p1z, p0, p8;
      longint unsigned zm, gm;
      bit zneg;
      ac1 = sx16(pred_cal_a[63:48]);
      ac2 = sx16(pred_cal_a[47:32]);
      ac3 = sx16(pred_cal_a[31:16]);
      ac4 = longint'(pred_cal_a[15:0]);
      ac5 = longint'(pred_cal_b[63:48]);
      ac6 = longint'(pred_cal_b[47:32]);
      vb1 = sx16(pred_cal_b[31:16]);
      vb2 = sx16(pred_cal_b[15:0]);
      mc = sx16(pred_cal_c[31:16]);
      md = sx16(pred_cal_c[15:0]);
      res.kind = cmd;
      res.temperature = pred_kept_temp;
      res.pressure = '0;
      res.status = ST_OK;
      if (cmd == CMD_TEMP) begin
         prod = ac5 * (longint'(raw) - ac6);
         dsum = prod + md * 32768;
         if (dsum == 0) begin
            res.status = ST_DIV0;
            return res;
         end
         a = apply_sign(scaled_quotient(magnitude(prod), FRAC_BITS - 15, 160, SAT61), prod < 0);
         q = apply_sign(scaled_quotient(magnitude(mc), FRAC_BITS + 21, magnitude(dsum) * 5,
                                        SAT61), (mc < 0) != (dsum < 0));
         t8 = shift_round(a + q, FRAC_BITS - 8);
         if (t8 > 32767) begin
            t8 = 32767;
            res.status = ST_SAT;
         end else if (t8 < -32768) begin
            t8 = -32768;
            res.status = ST_SAT;
         end
         pred_kept_temp = t8[15:0];
         res.temperature = t8[15:0];
      end else begin
         s8 = longint'(pred_kept_temp) - 6400;
         x31 = ac1 * (longint'(1) << 31) + ac2 * 5 * s8 * 32768 + vb2 * 25 * s8 * s8;
         y51 = (longint'(1) << 51) + ac3 * 5 * s8 * (longint'(1) << 18) + vb1 * 25 * s8 * s8;
         y35 = shift_round(y51, 16);
         if (ac4 == 0 || y35 == 0) begin
            res.status = ST_DIV0;
            return res;
         end
         n = (longint'(raw) * 256 + longint'(frac)) * (longint'(1) << 23) - x31;
         zm = scaled_quotient(magnitude(n) * 1000, FRAC_BITS + 4, ac4 * magnitude(y35),
                              64'd1 << (20 + FRAC_BITS));
         zneg = (n < 0) != (y35 < 0);
         z = apply_sign(zm, zneg);
         gm = scaled_product(zm, 303800, 36, SAT61);
         p2z2 = scaled_product(gm, zm, FRAC_BITS, SAT61);
         p1z = z - apply_sign(scaled_product(zm, 7357, 20, SAT61), zneg);
         p0 = scaled_quotient(3783, FRAC_BITS, 1600, SAT61);
         p8 = shift_round(p2z2 + p1z + p0, FRAC_BITS - 8);
         if (p8 > 524287) begin
            p8 = 524287;
            res.status = ST_SAT;
         end else if (p8 < 0) begin
            p8 = 0;
            res.status = ST_SAT;
         end
         res.pressure = p8[18:0];
      end
      return res;
   endfunction

   // ---------------- result checking and watchdog ----------------
   always @(negedge clock) begin
      reading_result_type want, got;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.temperature = rsp_tdata[15:0];
            got.pressure = rsp_tdata[34:16];
            got.status = rsp_tdata[36:35];
            if (pending_results.size() == 0) begin
               $error("unexpected result beat: %h", rsp_tdata);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.kind != want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, got.kind);
                  error_count++;
               end
               if (got.temperature != want.temperature) begin
                  $error("temperature: expected %0d, got %0d",
                         $signed(want.temperature), $signed(got.temperature));
                  error_count++;
               end
               if (got.pressure != want.pressure) begin
                  $error("pressure: expected %0d, got %0d", want.pressure, got.pressure);
                  error_count++;
               end
               if (got.status != want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------- stimulus helpers ----------------
   task automatic send_reading(input logic cmd, input logic [15:0] raw, input logic [7:0] frac);
      bit taken;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {frac, raw};
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
      pending_results.push_back(compensate(cmd, raw, frac));
   endtask

   task automatic wait_drained();
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_cal(input logic [1:0] index, input logic [63:0] value);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (index)
         CAL_A: pred_cal_a = value;
         CAL_B: pred_cal_b = value;
         default: pred_cal_c = {32'd0, value[31:0]};
      endcase
      @(posedge clock);
   endtask

   task automatic write_all_cal(input logic [63:0] a, input logic [63:0] b,
                                input logic [31:0] c);
      write_cal(CAL_A, a);
      write_cal(CAL_B, b);
      write_cal(CAL_C, {32'd0, c});
   endtask

   // ---------------- tests ----------------
   // everything zero after reset: both kinds hit a zero divisor
   task automatic test_reset_defaults();
      send_reading(CMD_TEMP, 16'd27898, 8'd0);
      send_reading(CMD_PRES, 16'd23843, 8'd128);
      wait_drained();
   endtask

   task automatic test_directed_cases();
      logic [63:0] nominal_a, nominal_b;
      logic [31:0] nominal_c;
      nominal_a = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
      nominal_b = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
      nominal_c = {-16'sd8711, 16'sd2868};
      write_all_cal(nominal_a, nominal_b, nominal_c);
      // field extremes and ordinary readings
      send_reading(CMD_TEMP, 16'd27898, 8'd0);
      send_reading(CMD_PRES, 16'd23843, 8'd0);
      send_reading(CMD_PRES, 16'd0, 8'd0);
      send_reading(CMD_PRES, 16'hFFFF, 8'hFF);
      send_reading(CMD_TEMP, 16'd0, 8'hFF);
      send_reading(CMD_PRES, 16'd30000, 8'h55);
      send_reading(CMD_TEMP, 16'hFFFF, 8'd0);
      send_reading(CMD_PRES, 16'h8000, 8'hAA);
      send_reading(CMD_TEMP, 16'd23153, 8'd0);
      wait_drained();
      // zero temperature divisor: raw equals AC6 and MD zero
      write_cal(CAL_C, {32'd0, -16'sd8711, 16'sd0});
      send_reading(CMD_TEMP, 16'd23153, 8'd7);
      send_reading(CMD_PRES, 16'd24000, 8'd1);
      wait_drained();
      // temperature saturation: large MC over a tiny divisor, both signs
      write_cal(CAL_C, {32'd0, 16'sd32767, 16'sd1});
      send_reading(CMD_TEMP, 16'd23153, 8'd0);
      send_reading(CMD_PRES, 16'd24000, 8'd0);
      wait_drained();
      write_cal(CAL_C, {32'd0, -16'sd32768, 16'sd1});
      send_reading(CMD_TEMP, 16'd23153, 8'd0);
      send_reading(CMD_PRES, 16'd24000, 8'd0);
      wait_drained();
      // zero pressure divisor: AC4 zero
      write_cal(CAL_A, {nominal_a[63:16], 16'd0});
      send_reading(CMD_PRES, 16'd24000, 8'd0);
      wait_drained();
      // extreme calibration: all ones, then the sign bit alone in most fields
      write_all_cal('1, '1, '1);
      send_reading(CMD_TEMP, 16'd100, 8'd0);
      send_reading(CMD_PRES, 16'hFFFF, 8'hFF);
      send_reading(CMD_PRES, 16'd0, 8'd0);
      wait_drained();
      write_all_cal(64'h8000_8000_8000_0001, 64'h0001_FFFF_8000_8000, 32'h8000_8000);
      send_reading(CMD_TEMP, 16'd0, 8'd0);
      send_reading(CMD_PRES, 16'hFFFF, 8'hFF);
      send_reading(CMD_PRES, 16'd1, 8'd0);
      wait_drained();
   endtask

   function automatic logic [15:0] jitter(input logic [15:0] v);
      return v + 16'($urandom_range(511)) - 16'd256;
   endfunction

   task automatic load_random_cal();
      if ($urandom_range(1)) begin
         write_all_cal({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      end else begin
         write_all_cal({jitter(16'd408), jitter(-16'sd72), jitter(-16'sd14383),
                        jitter(16'd32741)},
                       {jitter(16'd32757), jitter(16'd23153), jitter(16'sd6190),
                        jitter(16'sd4)},
                       {jitter(-16'sd8711), jitter(16'sd2868)});
      end
   endtask

   task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
      logic cmd;
      logic [15:0] raw;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      load_random_cal();
      for (int i = 0; i < items; i++) begin
         if (i % 150 == 149) begin
            // hold off until the block is empty, then move the calibration
            wait_drained();
            load_random_cal();
         end
         cmd = ($urandom_range(99) < 65) ? CMD_PRES : CMD_TEMP;
         raw = $urandom_range(3) == 0 ? 16'($urandom) :
               (cmd == CMD_TEMP ? 16'($urandom_range(32000, 20000)) :
                                  16'($urandom_range(30000, 18000)));
         send_reading(cmd, raw, 8'($urandom));
      end
      wait_drained();
   endtask

   initial begin
      pred_cal_a = '0;
      pred_cal_b = '0;
      pred_cal_c = '0;
      pred_kept_temp = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_cases();
      test_random_traffic(660, 21, 83);
      test_random_traffic(660, 83, 21);
      test_random_traffic(680, 0, 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
